@@ src/sbj_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package sbj_pkg;

  // Fixed field widths
  localparam int FILT_W   = 16;
  localparam int GT_W     = 8;
  localparam int PLOIDY_W = 3;
  localparam int CFG_W    = 16;
  localparam int FRAC_W   = 16;
  localparam int CFG_IDX_W = 1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAC_TOL = 1'b0,
    REG_ABS_TOL  = 1'b1
  } cfg_reg_t;

  localparam logic [CFG_W-1:0] FRAC_TOL_RESET = 16'd19661;
  localparam logic [CFG_W-1:0] ABS_TOL_RESET  = 16'd3;

  typedef struct packed {
    logic variant;
    logic any_cov;
    logic used_cov;
    logic gqx_def;
  } site_flags_t;

endpackage

`default_nettype wire

@@ src/sbj_fits.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Range [lo,hi] widened by v still within tolerance:
// 2 * (min + max(abs, floor(min * frac))) >= max
module sbj_fits #(
  parameter int VALUE_BITS = 16
) (
  input  wire logic [VALUE_BITS-1:0]         v,
  input  wire logic [VALUE_BITS-1:0]         lo,
  input  wire logic [VALUE_BITS-1:0]         hi,
  input  wire logic [sbj_pkg::FRAC_W-1:0]    frac_scale,
  input  wire logic [sbj_pkg::CFG_W-1:0]     abs_tol,
  output logic                               ok
);

  localparam int PROD_W = VALUE_BITS + sbj_pkg::FRAC_W;
  localparam int TOL_W  = (VALUE_BITS > sbj_pkg::CFG_W) ? VALUE_BITS : sbj_pkg::CFG_W;
  localparam int CMP_W  = TOL_W + 2;

  logic [VALUE_BITS-1:0] mn;
  logic [VALUE_BITS-1:0] mx;
  logic [PROD_W-1:0]     prod;
  logic [TOL_W-1:0]      ftol;
  logic [TOL_W-1:0]      atol;
  logic [TOL_W-1:0]      tol;
  logic [CMP_W-1:0]      lhs;

  always_comb begin
    mn   = (v < lo) ? v : lo;
    mx   = (v > hi) ? v : hi;
    prod = PROD_W'(mn) * PROD_W'(frac_scale);
    ftol = TOL_W'(prod[PROD_W-1:sbj_pkg::FRAC_W]);
    atol = TOL_W'(abs_tol);
    tol  = (ftol > atol) ? ftol : atol;
    lhs  = (CMP_W'(mn) + CMP_W'(tol)) << 1;
    ok   = lhs >= CMP_W'(mx);
  end

endmodule

`default_nettype wire

@@ src/sbj_block.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Open block state, join decision and close report for one site per enable.
module sbj_block #(
  parameter int POS_BITS    = 32,
  parameter int VALUE_BITS  = 16,
  parameter int LENGTH_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          en,
  input  wire logic [POS_BITS-1:0]           pos,
  input  wire logic [sbj_pkg::FILT_W-1:0]    site_filt,
  input  wire logic [sbj_pkg::FILT_W-1:0]    sample_filt,
  input  wire sbj_pkg::site_flags_t          flags,
  input  wire logic [VALUE_BITS-1:0]         used_d,
  input  wire logic [VALUE_BITS-1:0]         unused_d,
  input  wire logic [sbj_pkg::GT_W-1:0]      gt,
  input  wire logic [sbj_pkg::PLOIDY_W-1:0]  pl,
  input  wire logic [VALUE_BITS-1:0]         gqx,
  input  wire logic [sbj_pkg::FRAC_W-1:0]    frac_scale,
  input  wire logic [sbj_pkg::CFG_W-1:0]     abs_tol,
  output logic                               join_site,
  output logic                               c_valid,
  output logic [POS_BITS-1:0]                c_start,
  output logic [LENGTH_BITS-1:0]             c_length,
  output logic [VALUE_BITS-1:0]              c_used_min,
  output logic [VALUE_BITS-1:0]              c_used_max,
  output logic [VALUE_BITS-1:0]              c_unused_min,
  output logic [VALUE_BITS-1:0]              c_unused_max,
  output logic [VALUE_BITS-1:0]              c_gqx_min,
  output logic [VALUE_BITS-1:0]              c_gqx_max,
  output logic                               c_gqx_def
);

  logic [LENGTH_BITS-1:0]        blk_length;
  logic [POS_BITS-1:0]           blk_start;
  logic [sbj_pkg::FILT_W-1:0]    blk_site_filt;
  logic [sbj_pkg::FILT_W-1:0]    blk_sample_filt;
  sbj_pkg::site_flags_t          blk_flags;
  logic [sbj_pkg::GT_W-1:0]      blk_gt;
  logic [sbj_pkg::PLOIDY_W-1:0]  blk_pl;
  logic [VALUE_BITS-1:0]         used_min, used_max;
  logic [VALUE_BITS-1:0]         unused_min, unused_max;
  logic [VALUE_BITS-1:0]         gqx_min, gqx_max;

  logic                  used_ok, unused_ok, gqx_ok;
  logic                  empty, len_full, match;
  logic [POS_BITS-1:0]   next_pos;
  logic [VALUE_BITS-1:0] gqx_site;

  sbj_fits #(.VALUE_BITS(VALUE_BITS)) u_fits_used (
    .v(used_d), .lo(used_min), .hi(used_max),
    .frac_scale(frac_scale), .abs_tol(abs_tol), .ok(used_ok)
  );

  sbj_fits #(.VALUE_BITS(VALUE_BITS)) u_fits_unused (
    .v(unused_d), .lo(unused_min), .hi(unused_max),
    .frac_scale(frac_scale), .abs_tol(abs_tol), .ok(unused_ok)
  );

  sbj_fits #(.VALUE_BITS(VALUE_BITS)) u_fits_gqx (
    .v(gqx), .lo(gqx_min), .hi(gqx_max),
    .frac_scale(frac_scale), .abs_tol(abs_tol), .ok(gqx_ok)
  );

  always_comb begin
    empty    = blk_length == '0;
    len_full = blk_length == '1;
    next_pos = blk_start + POS_BITS'(blk_length);
    match    = !len_full
            && next_pos == pos
            && blk_site_filt == site_filt
            && blk_sample_filt == sample_filt
            && !blk_flags.variant && !flags.variant
            && used_ok && unused_ok
            && blk_flags.any_cov == flags.any_cov
            && blk_flags.used_cov == flags.used_cov
            && blk_gt == gt
            && blk_pl == pl
            && blk_flags.gqx_def == flags.gqx_def
            && (!flags.gqx_def || gqx_ok);
    join_site = empty || match;
    gqx_site  = flags.gqx_def ? gqx : '0;

    // Report the old block only when it closes; zeros otherwise
    c_valid      = !join_site;
    c_start      = join_site ? '0 : blk_start;
    c_length     = join_site ? '0 : blk_length;
    c_used_min   = join_site ? '0 : used_min;
    c_used_max   = join_site ? '0 : used_max;
    c_unused_min = join_site ? '0 : unused_min;
    c_unused_max = join_site ? '0 : unused_max;
    c_gqx_def    = !join_site && blk_flags.gqx_def;
    c_gqx_min    = c_gqx_def ? gqx_min : '0;
    c_gqx_max    = c_gqx_def ? gqx_max : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blk_length <= '0;
    end else if (en) begin
      if (empty || !join_site) begin
        blk_length <= LENGTH_BITS'(1);
      end else begin
        blk_length <= blk_length + LENGTH_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (empty || !join_site) begin
        // Start a fresh block from this site
        blk_start       <= pos;
        blk_site_filt   <= site_filt;
        blk_sample_filt <= sample_filt;
        blk_flags       <= flags;
        blk_gt          <= gt;
        blk_pl          <= pl;
        used_min        <= used_d;
        used_max        <= used_d;
        unused_min      <= unused_d;
        unused_max      <= unused_d;
        gqx_min         <= gqx_site;
        gqx_max         <= gqx_site;
      end else begin
        if (used_d < used_min)     used_min   <= used_d;
        if (used_d > used_max)     used_max   <= used_d;
        if (unused_d < unused_min) unused_min <= unused_d;
        if (unused_d > unused_max) unused_max <= unused_d;
        if (flags.gqx_def) begin
          if (gqx < gqx_min) gqx_min <= gqx;
          if (gqx > gqx_max) gqx_max <= gqx;
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ src/site_block_joiner_top.sv @@
// Pipeline: two register stages, the input register and then the result register; both
//   hold while the result output is stalled.
// Throughput: one site per cycle unless the output stalls; the join test (three tolerance
//   multipliers and compares) and min/max update close the block state loop unregistered.
// Reset: synchronous; clears valids and block length (no block open), tolerances to
//   their defaults.
`timescale 1ns / 1ps
`default_nettype none

module site_block_joiner_top #(
  parameter int POS_BITS    = 32,
  parameter int VALUE_BITS  = 16,
  parameter int LENGTH_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // configuration
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [sbj_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [sbj_pkg::CFG_W-1:0]     cfg_data,
  // site input
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [POS_BITS-1:0]           site_position,
  input  wire logic [sbj_pkg::FILT_W-1:0]    site_filters,
  input  wire logic [sbj_pkg::FILT_W-1:0]    sample_filters,
  input  wire logic                          is_variant,
  input  wire logic [VALUE_BITS-1:0]         used_depth,
  input  wire logic [VALUE_BITS-1:0]         unused_depth,
  input  wire logic                          any_coverage,
  input  wire logic                          used_coverage,
  input  wire logic [sbj_pkg::GT_W-1:0]      genotype_index,
  input  wire logic [sbj_pkg::PLOIDY_W-1:0]  ploidy,
  input  wire logic [VALUE_BITS-1:0]         gqx_value,
  input  wire logic                          gqx_defined,
  // result output
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               joined,
  output logic                               closed_valid,
  output logic [POS_BITS-1:0]                closed_start,
  output logic [LENGTH_BITS-1:0]             closed_length,
  output logic [VALUE_BITS-1:0]              closed_used_min,
  output logic [VALUE_BITS-1:0]              closed_used_max,
  output logic [VALUE_BITS-1:0]              closed_unused_min,
  output logic [VALUE_BITS-1:0]              closed_unused_max,
  output logic [VALUE_BITS-1:0]              closed_gqx_min,
  output logic [VALUE_BITS-1:0]              closed_gqx_max,
  output logic                               closed_gqx_defined
);

  logic [sbj_pkg::FRAC_W-1:0] frac_tolerance;
  logic [sbj_pkg::CFG_W-1:0]  abs_tolerance;

  // input register
  logic                          s1_valid;
  logic [POS_BITS-1:0]           s1_pos;
  logic [sbj_pkg::FILT_W-1:0]    s1_site_filt;
  logic [sbj_pkg::FILT_W-1:0]    s1_sample_filt;
  sbj_pkg::site_flags_t          s1_flags;
  logic [VALUE_BITS-1:0]         s1_used;
  logic [VALUE_BITS-1:0]         s1_unused;
  logic [sbj_pkg::GT_W-1:0]      s1_gt;
  logic [sbj_pkg::PLOIDY_W-1:0]  s1_pl;
  logic [VALUE_BITS-1:0]         s1_gqx;

  logic advance;
  logic take;

  logic                   r_join, r_valid, r_gqx_def;
  logic [POS_BITS-1:0]    r_start;
  logic [LENGTH_BITS-1:0] r_length;
  logic [VALUE_BITS-1:0]  r_used_min, r_used_max, r_unused_min, r_unused_max;
  logic [VALUE_BITS-1:0]  r_gqx_min, r_gqx_max;

  assign cfg_ready = 1'b1;
  assign advance   = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = s1_valid && !advance;
  assign take      = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      frac_tolerance <= sbj_pkg::FRAC_TOL_RESET;
      abs_tolerance  <= sbj_pkg::ABS_TOL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (sbj_pkg::cfg_reg_t'(cfg_index))
        sbj_pkg::REG_FRAC_TOL: frac_tolerance <= cfg_data;
        sbj_pkg::REG_ABS_TOL:  abs_tolerance  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_pos            <= site_position;
      s1_site_filt      <= site_filters;
      s1_sample_filt    <= sample_filters;
      s1_flags.variant  <= is_variant;
      s1_flags.any_cov  <= any_coverage;
      s1_flags.used_cov <= used_coverage;
      s1_flags.gqx_def  <= gqx_defined;
      s1_used           <= used_depth;
      s1_unused         <= unused_depth;
      s1_gt             <= genotype_index;
      s1_pl             <= ploidy;
      s1_gqx            <= gqx_value;
    end
  end

  sbj_block #(
    .POS_BITS(POS_BITS), .VALUE_BITS(VALUE_BITS), .LENGTH_BITS(LENGTH_BITS)
  ) u_block (
    .clk(clk), .rst(rst), .en(advance),
    .pos(s1_pos), .site_filt(s1_site_filt), .sample_filt(s1_sample_filt),
    .flags(s1_flags), .used_d(s1_used), .unused_d(s1_unused),
    .gt(s1_gt), .pl(s1_pl), .gqx(s1_gqx),
    .frac_scale(frac_tolerance), .abs_tol(abs_tolerance),
    .join_site(r_join), .c_valid(r_valid), .c_start(r_start), .c_length(r_length),
    .c_used_min(r_used_min), .c_used_max(r_used_max),
    .c_unused_min(r_unused_min), .c_unused_max(r_unused_max),
    .c_gqx_min(r_gqx_min), .c_gqx_max(r_gqx_max), .c_gqx_def(r_gqx_def)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      joined             <= r_join;
      closed_valid       <= r_valid;
      closed_start       <= r_start;
      closed_length      <= r_length;
      closed_used_min    <= r_used_min;
      closed_used_max    <= r_used_max;
      closed_unused_min  <= r_unused_min;
      closed_unused_max  <= r_unused_max;
      closed_gqx_min     <= r_gqx_min;
      closed_gqx_max     <= r_gqx_max;
      closed_gqx_defined <= r_gqx_def;
    end
  end

endmodule

`default_nettype wire

@@ src/sbj_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sbj_checker #(
  parameter int POS_BITS    = 32,
  parameter int VALUE_BITS  = 16,
  parameter int LENGTH_BITS = 16
) (
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   out_valid,
  input wire logic                   out_stall,
  input wire logic                   joined,
  input wire logic                   closed_valid,
  input wire logic [POS_BITS-1:0]    closed_start,
  input wire logic [LENGTH_BITS-1:0] closed_length,
  input wire logic [VALUE_BITS-1:0]  closed_used_min,
  input wire logic [VALUE_BITS-1:0]  closed_used_max,
  input wire logic [VALUE_BITS-1:0]  closed_gqx_min,
  input wire logic [VALUE_BITS-1:0]  closed_gqx_max,
  input wire logic                   closed_gqx_defined
);

  // a stalled result transaction holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(joined) && $stable(closed_valid)
      && $stable(closed_start) && $stable(closed_length))
    else $error("stalled result changed");

  // every site either joins or closes the old block
  a_join_xor_close: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> joined != closed_valid)
    else $error("joined and closed_valid disagree");

  a_closed_sane: assert property (@(posedge clk) disable iff (rst)
    out_valid && closed_valid |-> closed_length != '0 && closed_used_min <= closed_used_max)
    else $error("closed block has bad length or used depth range");

  a_no_gqx_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !closed_gqx_defined |-> closed_gqx_min == '0 && closed_gqx_max == '0)
    else $error("gqx extremes reported without gqx");

  a_open_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !closed_valid |-> closed_start == '0 && closed_length == '0
      && !closed_gqx_defined)
    else $error("closed fields set with no block closed");

endmodule

bind site_block_joiner_top sbj_checker #(
  .POS_BITS(POS_BITS), .VALUE_BITS(VALUE_BITS), .LENGTH_BITS(LENGTH_BITS)
) u_sbj_checker (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_stall(out_stall),
  .joined(joined), .closed_valid(closed_valid), .closed_start(closed_start),
  .closed_length(closed_length), .closed_used_min(closed_used_min),
  .closed_used_max(closed_used_max), .closed_gqx_min(closed_gqx_min),
  .closed_gqx_max(closed_gqx_max), .closed_gqx_defined(closed_gqx_defined)
);

`default_nettype wire
